// ===== src/vgh_pkg.sv =====
// vgh_pkg: shared types and constants of the voice gate with hangover and pre-roll
// holds the request structs, class and result codes, controller states and
// controller/datapath command and status structs; no dependencies
`timescale 1ns / 1ps

package vgh_pkg;

  localparam int HANDLE_WIDTH      = 16;
  localparam int PREROLL_DEPTH_DEF = 32;
  localparam int MAX_RESULTS       = 33;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_HANGOVER_LIMIT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PREROLL_LIMIT  = 1'd1;
  localparam logic [7:0] HANGOVER_LIMIT_RST = 8'd10;
  localparam logic [5:0] PREROLL_LIMIT_RST  = 6'd30;

  // voice activity classes
  localparam logic [2:0] CLS_BEGIN     = 3'd0;
  localparam logic [2:0] CLS_END       = 3'd1;
  localparam logic [2:0] CLS_BEGIN_END = 3'd2;
  localparam logic [2:0] CLS_SILENCE   = 3'd3;
  localparam logic [2:0] CLS_ACTIVE    = 3'd4;
  localparam logic [2:0] CLS_ERROR     = 3'd5;

  // result kinds
  localparam logic [1:0] KIND_NOTICE = 2'd0;
  localparam logic [1:0] KIND_CHUNK  = 2'd1;
  localparam logic [1:0] KIND_FLUSH  = 2'd2;

  typedef struct packed {
    logic [2:0]              vad_class;
    logic [HANDLE_WIDTH-1:0] chunk_handle;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              result_kind;
    logic [HANDLE_WIDTH-1:0] chunk_out;
    logic                    speaking_now;
    logic                    last_of_run;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_NOTICE,
    S_DRAIN,
    S_CURRENT,
    S_FLUSH
  } vgh_state_t;

  typedef struct packed {
    logic       capture;
    logic       eval;
    logic       emit;
    logic [1:0] kind;
    logic       from_store;
    logic       last;
    logic       step_idx;
    logic       clear_store;
  } vgh_cmd_t;

  typedef struct packed {
    logic notice_due;
    logic speaking;
    logic flush_due;
    logic fill_zero;
    logic drain_last;
    logic out_free;
  } vgh_stat_t;

endpackage

// ===== src/vgh_ram.sv =====
// vgh_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module vgh_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/vgh_ctrl.sv =====
// vgh_ctrl: controller state machine of the voice gate
// sequences capture, frame update and the result burst; uses vgh_pkg
`timescale 1ns / 1ps

module vgh_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  vgh_pkg::vgh_stat_t stat,
  output vgh_pkg::vgh_cmd_t  cmd
);
  import vgh_pkg::*;

  vgh_state_t state, state_next;
  vgh_state_t after_notice;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    if (stat.speaking) begin
      after_notice = stat.fill_zero ? S_CURRENT : S_DRAIN;
    end else begin
      after_notice = stat.flush_due ? S_FLUSH : S_IDLE;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EVAL;
      end
      S_EVAL: begin
        state_next = S_NOTICE;
      end
      S_NOTICE: begin
        if (!stat.notice_due || stat.out_free) state_next = after_notice;
      end
      S_DRAIN: begin
        if (stat.out_free && stat.drain_last) state_next = S_CURRENT;
      end
      S_CURRENT: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      S_FLUSH: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
      end
      S_NOTICE: begin
        if (stat.notice_due && stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = KIND_NOTICE;
          cmd.last = !stat.speaking && !stat.flush_due;
        end
      end
      S_DRAIN: begin
        if (stat.out_free) begin
          cmd.emit       = 1'b1;
          cmd.kind       = KIND_CHUNK;
          cmd.from_store = 1'b1;
          cmd.step_idx   = !stat.drain_last;
        end
      end
      S_CURRENT: begin
        if (stat.out_free) begin
          cmd.emit        = 1'b1;
          cmd.kind        = KIND_CHUNK;
          cmd.last        = 1'b1;
          cmd.clear_store = 1'b1;
        end
      end
      S_FLUSH: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = KIND_FLUSH;
          cmd.last = 1'b1;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  a_drain_has_data: assert property (@(posedge clk) disable iff (rst)
    state == S_DRAIN |-> !stat.fill_zero)
    else $error("drain entered with an empty pre-roll store");

  a_emit_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free)
    else $error("result loaded while output register still holds a request");

  a_idle_after_reset: assert property (@(posedge clk)
    $past(rst) |-> state == S_IDLE)
    else $error("controller not idle after reset");

endmodule

// ===== src/vgh_datapath.sv =====
// vgh_datapath: gate state, hangover counter, pre-roll ring and output register
// uses vgh_pkg and vgh_ram; driven by vgh_ctrl commands
`timescale 1ns / 1ps

module vgh_datapath #(
  parameter int PREROLL_DEPTH = vgh_pkg::PREROLL_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [vgh_pkg::CFG_INDEX_W-1:0]    cfg_addr,
  input  logic [vgh_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  vgh_pkg::in_item_t                  in_item,
  input  vgh_pkg::vgh_cmd_t                  cmd,
  output vgh_pkg::vgh_stat_t                 stat,
  input  logic                               out_ready,
  output logic                               out_valid,
  output vgh_pkg::out_item_t                 out_item
);
  import vgh_pkg::*;

  localparam int AW  = $clog2(PREROLL_DEPTH);
  localparam int CAP = (PREROLL_DEPTH < MAX_RESULTS - 2) ? PREROLL_DEPTH : MAX_RESULTS - 2;
  localparam int FW  = $clog2(CAP + 1);

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (AW+1)'(PREROLL_DEPTH)) s = s - (AW+1)'(PREROLL_DEPTH);
    return s[AW-1:0];
  endfunction

  logic [7:0]              hangover_limit;
  logic [5:0]              preroll_limit;
  logic                    speaking;
  logic                    reported;
  logic signed [8:0]       count;
  logic                    flush_due;
  logic                    notice_due;
  logic [FW-1:0]           fill;
  logic [AW-1:0]           head;
  logic [FW-1:0]           idx;
  logic [FW-1:0]           idx_next;
  logic [2:0]              cls;
  logic [HANDLE_WIDTH-1:0] chunk;

  logic signed [8:0]       cnt_dec, cnt_new;
  logic                    spk_new, rep_new, flush_new;
  logic [FW-1:0]           bound;
  logic                    drop;
  logic [AW-1:0]           head1;
  logic [FW-1:0]           fill1;
  logic [AW-1:0]           wr_addr, rd_addr;
  logic                    wr_en;
  logic [HANDLE_WIDTH-1:0] rd_data;
  logic                    out_free;
  out_item_t               emit_item;

  // frame update
  always_comb begin
    cnt_dec = (count <= 9'sd0) ? 9'sd0 : count - 9'sd1;
    cnt_new = cnt_dec;
    spk_new = speaking;
    rep_new = reported;
    case (cls)
      CLS_BEGIN, CLS_BEGIN_END, CLS_ACTIVE: begin
        spk_new = 1'b1;
        cnt_new = signed'({1'b0, hangover_limit});
      end
      CLS_END, CLS_SILENCE: begin
        cnt_new = cnt_dec - 9'sd1;
      end
      CLS_ERROR: begin
        spk_new = 1'b0;
      end
      default: begin
        rep_new = 1'b0;
      end
    endcase
    flush_new = spk_new && (cnt_new <= 9'sd0);
    if (flush_new) spk_new = 1'b0;
  end

  // pre-roll bound and ring update while silent
  always_comb begin
    if (preroll_limit == 6'd0) begin
      bound = FW'(1);
    end else if (preroll_limit > 6'(CAP)) begin
      bound = FW'(CAP);
    end else begin
      bound = FW'(preroll_limit);
    end
    drop    = fill >= bound;
    head1   = drop ? wrap_add(head, AW'(1)) : head;
    fill1   = drop ? fill - FW'(1) : fill;
    wr_addr = wrap_add(head1, AW'(fill1));
    wr_en   = cmd.eval && !spk_new;
  end

  // read address follows the index the next cycle will hold
  always_comb begin
    if (cmd.eval) begin
      idx_next = '0;
    end else if (cmd.step_idx) begin
      idx_next = idx + FW'(1);
    end else begin
      idx_next = idx;
    end
    rd_addr = wrap_add(head, AW'(idx_next));
  end

  vgh_ram #(
    .WIDTH (HANDLE_WIDTH),
    .DEPTH (PREROLL_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (chunk),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cls   <= in_item.vad_class;
      chunk <= in_item.chunk_handle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hangover_limit <= HANGOVER_LIMIT_RST;
      preroll_limit  <= PREROLL_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_HANGOVER_LIMIT: hangover_limit <= cfg_wdata;
        CFG_PREROLL_LIMIT:  preroll_limit  <= cfg_wdata[5:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speaking   <= 1'b0;
      reported   <= 1'b0;
      count      <= 9'sd0;
      flush_due  <= 1'b0;
      notice_due <= 1'b0;
      fill       <= '0;
      head       <= '0;
      idx        <= '0;
    end else begin
      idx <= idx_next;
      if (cmd.eval) begin
        speaking   <= spk_new;
        reported   <= spk_new;
        count      <= cnt_new;
        flush_due  <= flush_new;
        notice_due <= spk_new != rep_new;
        if (!spk_new) begin
          head <= head1;
          fill <= fill1 + FW'(1);
        end
      end
      if (cmd.clear_store) begin
        fill <= '0;
        head <= '0;
      end
    end
  end

  // output register
  assign out_free = !out_valid || out_ready;

  always_comb begin
    emit_item              = '0;
    emit_item.result_kind  = cmd.kind;
    emit_item.last_of_run  = cmd.last;
    case (cmd.kind)
      KIND_NOTICE: emit_item.speaking_now = speaking;
      KIND_CHUNK:  emit_item.chunk_out    = cmd.from_store ? rd_data : chunk;
      default:     emit_item.chunk_out    = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item <= emit_item;
    end
  end

  always_comb begin
    stat.notice_due = notice_due;
    stat.speaking   = speaking;
    stat.flush_due  = flush_due;
    stat.fill_zero  = fill == '0;
    stat.drain_last = idx == fill - FW'(1);
    stat.out_free   = out_free;
  end

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(CAP))
    else $error("pre-roll fill above its bound");

  a_flush_closes_gate: assert property (@(posedge clk) disable iff (rst)
    !(speaking && flush_due))
    else $error("flusher pending while gate still open");

endmodule

// ===== src/voice_gate_hangover_preroll_top.sv =====
// voice_gate_hangover_preroll_top: top level of the voice gate with hangover and pre-roll
// joins vgh_ctrl and vgh_datapath; uses vgh_pkg
`timescale 1ns / 1ps

// Frame-rate voice gate. Each input request carries a voice-activity class and a chunk
// handle; the block answers with a burst of results (status notice, forwarded chunks,
// flusher marker), the last one flagged by last_of_run; a frame that needs no result
// gets none. Frames are handled one at a time: a frame is accepted, then updated, then
// given a notice slot, then its forwarded chunks or flusher are sent. Stored chunks
// come from the single read port of the pre-roll ram, which gives one stored chunk per
// cycle while the output register is free. The next frame is taken as soon as the last
// result of the previous one sits in the output register. The pre-roll ram is never
// cleared; only entries covered by the fill count are read.
// The user must write configuration registers only while the block is idle; the block
// itself does not enforce this.
module voice_gate_hangover_preroll_top #(
  parameter int PREROLL_DEPTH = vgh_pkg::PREROLL_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [vgh_pkg::CFG_INDEX_W-1:0] cfg_addr,
  input  logic [vgh_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  vgh_pkg::in_item_t               in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output vgh_pkg::out_item_t              out_item
);
  import vgh_pkg::*;

  vgh_cmd_t  cmd;
  vgh_stat_t stat;

  vgh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  vgh_datapath #(
    .PREROLL_DEPTH (PREROLL_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
